[rtl/httpflash_pkg.sv]
// Shared types, codes and character constants of the HTTP response to flash page receiver.
`default_nettype none

package httpflash_pkg;

   // Event kinds on the request channel; any other code is handled as a close.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [2:0] STATUS_BAD_HTTP  = 3'd1;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd2;
   localparam logic [2:0] STATUS_FINISHED  = 3'd3;
   localparam logic [2:0] STATUS_IGNORED   = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [0:0] REG_BASE_ADDR = 1'b0;
   localparam logic [0:0] REG_MAX_SIZE  = 1'b1;
   localparam int unsigned CSR_ADDR_W   = 3;

   localparam int unsigned COMMIT_LEN_W = 9;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_C     = 8'h43;

   localparam logic [3:0] STATUS_WORD_LEN = 4'd8;
   localparam logic [3:0] LENGTH_WORD_LEN = 4'd15;

   localparam logic signed [31:0] HTTP_OK   = 32'sd200;
   localparam logic [30:0]        VALUE_MAX = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      NP_SKIP   = 2'd0,
      NP_SIGN   = 2'd1,
      NP_DIGITS = 2'd2,
      NP_DONE   = 2'd3
   } number_phase_type;

   // Characters of the status line prefix "HTTP/1.1".
   function automatic logic [7:0] status_char(input logic [2:0] idx);
      logic [7:0] ch;
      begin
         case (idx)
            3'd0: ch = 8'h48;
            3'd1: ch = 8'h54;
            3'd2: ch = 8'h54;
            3'd3: ch = 8'h50;
            3'd4: ch = 8'h2F;
            3'd5: ch = 8'h31;
            3'd6: ch = 8'h2E;
            default: ch = 8'h31;
         endcase
         return ch;
      end
   endfunction

   // Characters of the header prefix "Content-Length:".
   function automatic logic [7:0] length_char(input logic [3:0] idx);
      logic [7:0] ch;
      begin
         case (idx)
            4'd0:  ch = 8'h43;
            4'd1:  ch = 8'h6F;
            4'd2:  ch = 8'h6E;
            4'd3:  ch = 8'h74;
            4'd4:  ch = 8'h65;
            4'd5:  ch = 8'h6E;
            4'd6:  ch = 8'h74;
            4'd7:  ch = 8'h2D;
            4'd8:  ch = 8'h4C;
            4'd9:  ch = 8'h65;
            4'd10: ch = 8'h6E;
            4'd11: ch = 8'h67;
            4'd12: ch = 8'h74;
            4'd13: ch = 8'h68;
            4'd14: ch = 8'h3A;
            default: ch = 8'h00;
         endcase
         return ch;
      end
   endfunction

endpackage

`default_nettype wire

[rtl/httpflash_req_if.sv]
// Request channel: one event (start, received byte or close) per transfer.
`default_nettype none

interface httpflash_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/httpflash_rsp_if.sv]
// Response channel: one result per request event.
`default_nettype none

interface httpflash_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        store_valid;
   logic [31:0] store_addr;
   logic [7:0]  store_byte;
   logic        commit_valid;
   logic [31:0] commit_addr;
   logic [8:0]  commit_len;
   logic [31:0] total_bytes;
   logic        in_body;

   modport source (output valid, output status, output store_valid, output store_addr,
                   output store_byte, output commit_valid, output commit_addr,
                   output commit_len, output total_bytes, output in_body, input ready);
   modport sink   (input valid, input status, input store_valid, input store_addr,
                   input store_byte, input commit_valid, input commit_addr,
                   input commit_len, input total_bytes, input in_body, output ready);
endinterface

`default_nettype wire

[rtl/http_response_to_flash_pages_core.sv]
// HTTP response receiver that parses the header and maps body bytes onto flash pages.
//
// Each request transfer carries one event: start, a received byte or a close. The event
// is captured in an input register, and in the following cycle one pass of header
// parsing, limit checking and page address logic updates the state and loads the result
// register, so one event is taken every cycle and its result is offered from the clock
// edge after the transfer when the response side is not stalled. While a result waits, the
// input register still takes one more event before the request side stalls. The decimal
// accumulation (one multiply by ten and a saturating compare) sets the longest path. The
// user must write configuration via the APB port while no event is in flight; unenforced.
`default_nettype none

module http_response_to_flash_pages_core #(
   parameter int unsigned PAGE_BYTES = 256,
   parameter int unsigned LINE_MAX   = 256
) (
   input  wire                                      clock,
   input  wire                                      reset,
   httpflash_req_if.sink                            req_ch,
   httpflash_rsp_if.source                          rsp_ch,
   input  wire                                      psel,
   input  wire                                      penable,
   input  wire                                      pwrite,
   input  wire  [httpflash_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire  [31:0]                              pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);

   localparam int unsigned LC_W   = $clog2(LINE_MAX + 1);
   localparam int unsigned FILL_W = $clog2(PAGE_BYTES + 1);

   localparam logic [31:0] PAGE_BYTES_32   = 32'(PAGE_BYTES);
   localparam logic [8:0]  COMMIT_LEN_FULL = PAGE_BYTES_32[8:0];

   // Configuration registers.
   logic [31:0] base_addr_ff;
   logic [30:0] max_size_ff;

   // Input register.
   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   logic [7:0] in_byte_ff;

   // Parser and page state.
   httpflash_pkg::phase_type        phase_ff, phase_in;
   logic [LC_W-1:0]                 line_count_ff, line_count_in;
   logic [3:0]                      prefix_pos_ff, prefix_pos_in;
   logic                            status_alive_ff, status_alive_in;
   logic                            length_alive_ff, length_alive_in;
   httpflash_pkg::number_phase_type number_phase_ff, number_phase_in;
   logic                            negative_ff, negative_in;
   logic [30:0]                     number_value_ff, number_value_in;
   logic signed [31:0]              size_limit_ff, size_limit_in;
   logic [31:0]                     page_addr_ff, page_addr_in;
   logic [FILL_W-1:0]               page_fill_ff, page_fill_in;
   logic [31:0]                     total_count_ff, total_count_in;

   // Result register.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic        store_valid_ff, store_valid_in;
   logic [31:0] store_addr_ff, store_addr_in;
   logic [7:0]  store_byte_ff, store_byte_in;
   logic        commit_valid_ff, commit_valid_in;
   logic [31:0] commit_addr_ff, commit_addr_in;
   logic [8:0]  commit_len_ff, commit_len_in;
   logic        in_body_ff, in_body_in;

   logic                advance;
   logic                csr_write;
   logic                has_number;
   logic signed [31:0]  number_signed;
   logic                is_digit;
   logic                is_space;
   logic [3:0]          digit;
   logic [34:0]         accum;
   logic [30:0]         accum_sat;
   logic [7:0]          word_char;
   logic [3:0]          word_len;
   logic                line_full;
   logic [FILL_W-1:0]   fill_next;
   logic [31:0]         fill_ext;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_addr_ff <= '0;
         max_size_ff  <= '0;
      end else if (csr_write) begin
         unique case (paddr[2])
            httpflash_pkg::REG_BASE_ADDR: base_addr_ff <= pwdata;
            httpflash_pkg::REG_MAX_SIZE:  max_size_ff  <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         httpflash_pkg::REG_BASE_ADDR: prdata = base_addr_ff;
         httpflash_pkg::REG_MAX_SIZE:  prdata = {1'b0, max_size_ff};
         default:                      prdata = '0;
      endcase
   end

   // ---------------- input register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_kind_ff <= req_ch.kind;
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   // ---------------- character classification ----------------
   assign is_digit  = (in_byte_ff >= httpflash_pkg::CHAR_ZERO) &&
                      (in_byte_ff <= httpflash_pkg::CHAR_NINE);
   assign is_space  = (in_byte_ff == httpflash_pkg::CHAR_SPACE) ||
                      (in_byte_ff == httpflash_pkg::CHAR_TAB) ||
                      (in_byte_ff == httpflash_pkg::CHAR_VT) ||
                      (in_byte_ff == httpflash_pkg::CHAR_FF);
   assign digit     = 4'(in_byte_ff - httpflash_pkg::CHAR_ZERO);
   assign accum     = ({4'b0, number_value_ff} * 35'd10) + {31'b0, digit};
   assign accum_sat = (accum > {4'b0, httpflash_pkg::VALUE_MAX}) ?
                      httpflash_pkg::VALUE_MAX : accum[30:0];

   // The surviving prefix decides which word is compared; both cannot survive together.
   assign word_char = status_alive_ff ? httpflash_pkg::status_char(prefix_pos_ff[2:0])
                                      : httpflash_pkg::length_char(prefix_pos_ff);
   assign word_len  = status_alive_ff ? httpflash_pkg::STATUS_WORD_LEN
                                      : httpflash_pkg::LENGTH_WORD_LEN;
   assign line_full = line_count_ff >= LC_W'(LINE_MAX);

   assign has_number    = (number_phase_ff == httpflash_pkg::NP_DIGITS) ||
                          (number_phase_ff == httpflash_pkg::NP_DONE);
   assign number_signed = negative_ff ? -$signed({1'b0, number_value_ff})
                                      : $signed({1'b0, number_value_ff});
   assign fill_next     = page_fill_ff + FILL_W'(1);
   assign fill_ext      = 32'(page_fill_ff);

   // ---------------- one event per pass ----------------
   always_comb begin
      phase_in        = phase_ff;
      line_count_in   = line_count_ff;
      prefix_pos_in   = prefix_pos_ff;
      status_alive_in = status_alive_ff;
      length_alive_in = length_alive_ff;
      number_phase_in = number_phase_ff;
      negative_in     = negative_ff;
      number_value_in = number_value_ff;
      size_limit_in   = size_limit_ff;
      page_addr_in    = page_addr_ff;
      page_fill_in    = page_fill_ff;
      total_count_in  = total_count_ff;

      status_in       = httpflash_pkg::STATUS_ACCEPTED;
      store_valid_in  = 1'b0;
      store_addr_in   = '0;
      store_byte_in   = '0;
      commit_valid_in = 1'b0;
      commit_addr_in  = '0;
      commit_len_in   = '0;

      if (in_kind_ff == httpflash_pkg::KIND_START) begin
         phase_in        = httpflash_pkg::PH_HEAD;
         line_count_in   = '0;
         prefix_pos_in   = '0;
         status_alive_in = 1'b1;
         length_alive_in = 1'b1;
         number_phase_in = httpflash_pkg::NP_SKIP;
         negative_in     = 1'b0;
         number_value_in = '0;
         size_limit_in   = $signed({1'b0, max_size_ff});
         page_addr_in    = base_addr_ff;
         page_fill_in    = '0;
         total_count_in  = '0;
      end else if (phase_ff == httpflash_pkg::PH_IDLE) begin
         status_in = httpflash_pkg::STATUS_IGNORED;
      end else if (in_kind_ff == httpflash_pkg::KIND_BYTE &&
                   phase_ff == httpflash_pkg::PH_HEAD) begin
         if (in_byte_ff == httpflash_pkg::CHAR_LF) begin
            if (line_count_ff != '0) begin
               if (status_alive_ff && prefix_pos_ff == httpflash_pkg::STATUS_WORD_LEN &&
                   has_number) begin
                  if (number_signed != httpflash_pkg::HTTP_OK) begin
                     status_in = httpflash_pkg::STATUS_BAD_HTTP;
                     phase_in  = httpflash_pkg::PH_IDLE;
                  end
               end else if (length_alive_ff &&
                            prefix_pos_ff == httpflash_pkg::LENGTH_WORD_LEN && has_number) begin
                  if (number_signed > size_limit_ff) begin
                     status_in = httpflash_pkg::STATUS_TOO_LONG;
                     phase_in  = httpflash_pkg::PH_IDLE;
                  end else begin
                     size_limit_in = number_signed;
                  end
               end
               line_count_in   = '0;
               prefix_pos_in   = '0;
               status_alive_in = 1'b1;
               length_alive_in = 1'b1;
               number_phase_in = httpflash_pkg::NP_SKIP;
               negative_in     = 1'b0;
               number_value_in = '0;
            end else begin
               // An empty line closes the header.
               phase_in       = httpflash_pkg::PH_BODY;
               total_count_in = '0;
               page_fill_in   = '0;
            end
         end else if (in_byte_ff != httpflash_pkg::CHAR_CR && !line_full) begin
            line_count_in = line_count_ff + LC_W'(1);
            if (in_byte_ff == httpflash_pkg::CHAR_NUL) begin
               // A NUL ends the text: a number already begun stays, anything else fails.
               if (prefix_pos_ff == '0 || !has_number) begin
                  status_alive_in = 1'b0;
                  length_alive_in = 1'b0;
               end else if (number_phase_ff == httpflash_pkg::NP_DIGITS) begin
                  number_phase_in = httpflash_pkg::NP_DONE;
               end
            end else if (!status_alive_ff && !length_alive_ff) begin
               // The line has already failed to match; only its length is tracked.
            end else if (prefix_pos_ff == '0) begin
               status_alive_in = (in_byte_ff == httpflash_pkg::CHAR_H);
               length_alive_in = (in_byte_ff == httpflash_pkg::CHAR_C);
               if (in_byte_ff == httpflash_pkg::CHAR_H || in_byte_ff == httpflash_pkg::CHAR_C) begin
                  prefix_pos_in = 4'd1;
               end
            end else if (prefix_pos_ff < word_len) begin
               if (in_byte_ff == word_char) begin
                  prefix_pos_in = prefix_pos_ff + 4'd1;
               end else begin
                  status_alive_in = 1'b0;
                  length_alive_in = 1'b0;
               end
            end else begin
               case (number_phase_ff)
                  httpflash_pkg::NP_SKIP: begin
                     if (is_space) begin
                        // Leading whitespace before the number is skipped.
                     end else if (in_byte_ff == httpflash_pkg::CHAR_PLUS ||
                                  in_byte_ff == httpflash_pkg::CHAR_MINUS) begin
                        negative_in     = (in_byte_ff == httpflash_pkg::CHAR_MINUS);
                        number_phase_in = httpflash_pkg::NP_SIGN;
                     end else if (is_digit) begin
                        number_value_in = {27'b0, digit};
                        number_phase_in = httpflash_pkg::NP_DIGITS;
                     end else begin
                        status_alive_in = 1'b0;
                        length_alive_in = 1'b0;
                     end
                  end
                  httpflash_pkg::NP_SIGN: begin
                     if (is_digit) begin
                        number_value_in = {27'b0, digit};
                        number_phase_in = httpflash_pkg::NP_DIGITS;
                     end else begin
                        status_alive_in = 1'b0;
                        length_alive_in = 1'b0;
                     end
                  end
                  httpflash_pkg::NP_DIGITS: begin
                     if (is_digit) begin
                        number_value_in = accum_sat;
                     end else begin
                        number_phase_in = httpflash_pkg::NP_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end else if (in_kind_ff == httpflash_pkg::KIND_BYTE) begin
         total_count_in = total_count_ff + 32'd1;
         store_valid_in = 1'b1;
         store_addr_in  = page_addr_ff + fill_ext;
         store_byte_in  = in_byte_ff;
         page_fill_in   = fill_next;
         if (fill_next >= FILL_W'(PAGE_BYTES)) begin
            commit_valid_in = 1'b1;
            commit_addr_in  = page_addr_ff;
            commit_len_in   = COMMIT_LEN_FULL;
            page_addr_in    = page_addr_ff + 32'(PAGE_BYTES);
            page_fill_in    = '0;
         end
      end else begin
         // Close: flush a partly filled page.
         if (phase_ff == httpflash_pkg::PH_BODY && page_fill_ff != '0) begin
            commit_valid_in = 1'b1;
            commit_addr_in  = page_addr_ff;
            commit_len_in   = fill_ext[8:0];
            page_addr_in    = page_addr_ff + fill_ext;
            page_fill_in    = '0;
         end
         status_in = httpflash_pkg::STATUS_FINISHED;
         phase_in  = httpflash_pkg::PH_IDLE;
      end

      in_body_in = (phase_in == httpflash_pkg::PH_BODY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= httpflash_pkg::PH_IDLE;
         line_count_ff   <= '0;
         prefix_pos_ff   <= '0;
         status_alive_ff <= 1'b1;
         length_alive_ff <= 1'b1;
         number_phase_ff <= httpflash_pkg::NP_SKIP;
         negative_ff     <= 1'b0;
         number_value_ff <= '0;
         size_limit_ff   <= '0;
         page_addr_ff    <= '0;
         page_fill_ff    <= '0;
         total_count_ff  <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         line_count_ff   <= line_count_in;
         prefix_pos_ff   <= prefix_pos_in;
         status_alive_ff <= status_alive_in;
         length_alive_ff <= length_alive_in;
         number_phase_ff <= number_phase_in;
         negative_ff     <= negative_in;
         number_value_ff <= number_value_in;
         size_limit_ff   <= size_limit_in;
         page_addr_ff    <= page_addr_in;
         page_fill_ff    <= page_fill_in;
         total_count_ff  <= total_count_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff       <= status_in;
         store_valid_ff  <= store_valid_in;
         store_addr_ff   <= store_addr_in;
         store_byte_ff   <= store_byte_in;
         commit_valid_ff <= commit_valid_in;
         commit_addr_ff  <= commit_addr_in;
         commit_len_ff   <= commit_len_in;
         in_body_ff      <= in_body_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.store_valid  = store_valid_ff;
   assign rsp_ch.store_addr   = store_addr_ff;
   assign rsp_ch.store_byte   = store_byte_ff;
   assign rsp_ch.commit_valid = commit_valid_ff;
   assign rsp_ch.commit_addr  = commit_addr_ff;
   assign rsp_ch.commit_len   = commit_len_ff;
   assign rsp_ch.total_bytes  = total_count_ff;
   assign rsp_ch.in_body      = in_body_ff;

endmodule

`default_nettype wire

[rtl/httpflash_checker.sv]
// Port-level checks on the response channel of the receiver, bound to the receiver core.
`default_nettype none

module httpflash_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_status,
   input wire        rsp_store_valid,
   input wire        rsp_commit_valid,
   input wire        rsp_in_body
);

   // A stored byte only comes from an accepted body byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_valid |->
         rsp_in_body && rsp_status == httpflash_pkg::STATUS_ACCEPTED)
      else $error("store outside body or with a non-accepted status");

   // Finishing or aborting always leaves body mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == httpflash_pkg::STATUS_FINISHED ||
                    rsp_status == httpflash_pkg::STATUS_BAD_HTTP ||
                    rsp_status == httpflash_pkg::STATUS_TOO_LONG) |->
         !rsp_in_body && !rsp_store_valid)
      else $error("end of transfer still reports body mode");

   // A page commit comes with a stored byte or with a close.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_commit_valid |->
         rsp_store_valid || rsp_status == httpflash_pkg::STATUS_FINISHED)
      else $error("page commit without a body byte or a close");

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

endmodule

bind http_response_to_flash_pages_core httpflash_checker u_httpflash_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_store_valid  (rsp_ch.store_valid),
   .rsp_commit_valid (rsp_ch.commit_valid),
   .rsp_in_body      (rsp_ch.in_body)
);

`default_nettype wire
